### rtl/periodic_pulse_generator_fsm_macros.svh
// assertion macros for the periodic pulse generator
// used by the controller, no other dependencies
`ifndef PERIODIC_PULSE_GENERATOR_FSM_MACROS_SVH
`define PERIODIC_PULSE_GENERATOR_FSM_MACROS_SVH

// same-cycle implication
`define PPG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PPG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/ppg_pkg.sv
// shared types and constants of the periodic pulse generator
// no dependencies
`default_nettype none

package ppg_pkg;

   localparam int unsigned TICKS_PER_SECOND = 1000000;
   localparam int TICK_WIDTH = 20;
   localparam int FREQ_WIDTH = 16;
   localparam int DIV_STEPS = TICK_WIDTH;
   localparam int DIV_CNT_WIDTH = $clog2(DIV_STEPS);
   localparam logic [TICK_WIDTH-1:0] TICKS_CONST = TICK_WIDTH'(TICKS_PER_SECOND);
   localparam logic [FREQ_WIDTH-1:0] MAX_FREQ_RESET = 16'd10000;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam logic CSR_IDX_MAX_FREQ = 1'b0;

   typedef enum logic [2:0] {
      CMD_SET_FREQ = 3'd0,
      CMD_START    = 3'd1,
      CMD_STOP     = 3'd2,
      CMD_TICK     = 3'd3,
      CMD_ACK      = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_INITIAL = 2'd0,
      MODE_STOPPED = 2'd1,
      MODE_PULSING = 2'd2,
      MODE_WAITING = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      FSM_IDLE   = 2'd0,
      FSM_DECODE = 2'd1,
      FSM_DIVIDE = 2'd2,
      FSM_FINISH = 2'd3
   } fsm_type;

   typedef struct packed {
      logic       load_item;
      logic       div_start;
      logic       div_step;
      logic       period_load;
      logic       rem_reload;
      logic       rem_dec;
      logic       arm_set;
      logic       arm_clr;
      logic       rsp_load;
      logic       rsp_pulse;
      logic       rsp_missed;
      logic       rsp_error;
      logic [1:0] rsp_state_code;
   } dp_cmd_type;

   typedef struct packed {
      logic [2:0] cmd;
      logic       freq_bad;
      logic       rem_le1;
      logic       armed;
      logic       div_last;
   } dp_sts_type;

endpackage

`default_nettype wire

### rtl/ppg_dpath.sv
// datapath: item registers, serial divider, tick counter, csr and result beat
// depends on ppg_pkg
`default_nettype none

module ppg_dpath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [2:0]                           req_command,
   input  logic [ppg_pkg::FREQ_WIDTH-1:0]       req_frequency,
   output logic                                 rsp_pulse,
   output logic                                 rsp_missed,
   output logic                                 rsp_error,
   output logic [1:0]                           rsp_state_code,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [ppg_pkg::CSR_ADDR_WIDTH-1:0]   csr_paddr,
   input  logic [31:0]                          csr_pwdata,
   output logic [31:0]                          csr_prdata,
   output logic                                 csr_pready,
   input  ppg_pkg::dp_cmd_type                  dp_cmd,
   output ppg_pkg::dp_sts_type                  dp_sts
);
   import ppg_pkg::*;

   logic [2:0]               cmd_ff;
   logic [FREQ_WIDTH-1:0]    freq_ff;
   logic [FREQ_WIDTH-1:0]    max_freq_ff, max_freq_in;
   logic [TICK_WIDTH-1:0]    period_ff, period_in;
   logic [TICK_WIDTH-1:0]    remaining_ff, remaining_in;
   logic                     armed_ff, armed_in;
   logic [TICK_WIDTH-1:0]    quo_ff, quo_in;
   logic [FREQ_WIDTH:0]      rem_ff, rem_in;
   logic [DIV_CNT_WIDTH-1:0] div_cnt_ff, div_cnt_in;
   logic                     pulse_ff, missed_ff, error_ff;
   logic [1:0]               state_code_ff;

   logic [FREQ_WIDTH:0]      rem_shift;
   logic [FREQ_WIDTH:0]      divisor;
   logic                     quo_bit;
   logic [TICK_WIDTH-1:0]    reload;
   logic                     csr_wr;

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == CSR_IDX_MAX_FREQ) ? {16'b0, max_freq_ff} : 32'b0;

   // one restoring step a cycle
   assign divisor   = {1'b0, freq_ff};
   assign rem_shift = {rem_ff[FREQ_WIDTH-1:0], quo_ff[TICK_WIDTH-1]};
   assign quo_bit   = (rem_shift >= divisor);
   assign reload    = (period_ff == '0) ? TICK_WIDTH'(1) : period_ff;

   always_comb begin
      max_freq_in  = max_freq_ff;
      period_in    = period_ff;
      remaining_in = remaining_ff;
      armed_in     = armed_ff;
      quo_in       = quo_ff;
      rem_in       = rem_ff;
      div_cnt_in   = div_cnt_ff;
      if (csr_wr && csr_paddr[2] == CSR_IDX_MAX_FREQ) begin
         max_freq_in = csr_pwdata[FREQ_WIDTH-1:0];
      end
      if (dp_cmd.div_start) begin
         quo_in     = TICKS_CONST;
         rem_in     = '0;
         div_cnt_in = '0;
      end else if (dp_cmd.div_step) begin
         quo_in     = {quo_ff[TICK_WIDTH-2:0], quo_bit};
         rem_in     = quo_bit ? (rem_shift - divisor) : rem_shift;
         div_cnt_in = div_cnt_ff + 1'b1;
      end
      if (dp_cmd.period_load) begin
         period_in = (quo_ff == '0) ? TICK_WIDTH'(1) : quo_ff;
      end
      if (dp_cmd.rem_reload) begin
         remaining_in = reload;
      end else if (dp_cmd.rem_dec) begin
         remaining_in = remaining_ff - 1'b1;
      end
      if (dp_cmd.arm_set) begin
         armed_in = 1'b1;
      end else if (dp_cmd.arm_clr) begin
         armed_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_freq_ff  <= MAX_FREQ_RESET;
         period_ff    <= '0;
         remaining_ff <= '0;
         armed_ff     <= 1'b0;
         div_cnt_ff   <= '0;
      end else begin
         max_freq_ff  <= max_freq_in;
         period_ff    <= period_in;
         remaining_ff <= remaining_in;
         armed_ff     <= armed_in;
         div_cnt_ff   <= div_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      if (dp_cmd.load_item) begin
         cmd_ff  <= req_command;
         freq_ff <= req_frequency;
      end
      if (dp_cmd.rsp_load) begin
         pulse_ff      <= dp_cmd.rsp_pulse;
         missed_ff     <= dp_cmd.rsp_missed;
         error_ff      <= dp_cmd.rsp_error;
         state_code_ff <= dp_cmd.rsp_state_code;
      end
   end

   assign dp_sts.cmd      = cmd_ff;
   assign dp_sts.freq_bad = (freq_ff == '0) || (freq_ff >= max_freq_ff);
   assign dp_sts.rem_le1  = (remaining_ff <= TICK_WIDTH'(1));
   assign dp_sts.armed    = armed_ff;
   assign dp_sts.div_last = (div_cnt_ff == DIV_CNT_WIDTH'(DIV_STEPS - 1));

   assign rsp_pulse      = pulse_ff;
   assign rsp_missed     = missed_ff;
   assign rsp_error      = error_ff;
   assign rsp_state_code = state_code_ff;

endmodule

`default_nettype wire

### rtl/ppg_ctrl.sv
// controller: item sequencing, timer mode and result beat valid
// depends on ppg_pkg and periodic_pulse_generator_fsm_macros.svh
`default_nettype none

module ppg_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output ppg_pkg::dp_cmd_type dp_cmd,
   input  ppg_pkg::dp_sts_type dp_sts
);
   import ppg_pkg::*;
   `include "periodic_pulse_generator_fsm_macros.svh"

   fsm_type  fsm_ff, fsm_in;
   mode_type mode_ff, mode_in;
   logic     rsp_valid_ff, rsp_valid_in;
   logic     slot_free;
   logic     freq_ok;

   assign slot_free = !rsp_valid_ff || !rsp_stall;
   assign freq_ok   = (dp_sts.cmd == CMD_SET_FREQ) && !dp_sts.freq_bad;

   always_comb begin
      fsm_in = fsm_ff;
      case (fsm_ff)
         FSM_IDLE: begin
            if (req_valid) fsm_in = FSM_DECODE;
         end
         FSM_DECODE: begin
            fsm_in = freq_ok ? FSM_DIVIDE : FSM_FINISH;
         end
         FSM_DIVIDE: begin
            if (dp_sts.div_last) fsm_in = FSM_FINISH;
         end
         FSM_FINISH: begin
            if (slot_free) fsm_in = FSM_IDLE;
         end
         default: fsm_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      dp_cmd    = '0;
      mode_in   = mode_ff;
      req_stall = 1'b1;
      case (fsm_ff)
         FSM_IDLE: begin
            req_stall        = 1'b0;
            dp_cmd.load_item = req_valid;
         end
         FSM_DECODE: begin
            dp_cmd.div_start = freq_ok;
         end
         FSM_DIVIDE: begin
            dp_cmd.div_step = 1'b1;
         end
         FSM_FINISH: begin
            if (slot_free) begin
               dp_cmd.rsp_load = 1'b1;
               case (dp_sts.cmd)
                  CMD_SET_FREQ: begin
                     if (dp_sts.freq_bad) begin
                        dp_cmd.rsp_error = 1'b1;
                        dp_cmd.arm_clr   = 1'b1;
                        mode_in          = MODE_INITIAL;
                     end else begin
                        dp_cmd.period_load = 1'b1;
                        if (mode_ff == MODE_INITIAL) mode_in = MODE_STOPPED;
                     end
                  end
                  CMD_START: begin
                     if (mode_ff == MODE_STOPPED) begin
                        mode_in           = MODE_PULSING;
                        dp_cmd.arm_set    = 1'b1;
                        dp_cmd.rem_reload = 1'b1;
                     end else begin
                        dp_cmd.rsp_error = 1'b1;
                     end
                  end
                  CMD_STOP: begin
                     if (mode_ff == MODE_INITIAL) begin
                        dp_cmd.rsp_error = 1'b1;
                     end else begin
                        mode_in        = MODE_STOPPED;
                        dp_cmd.arm_clr = 1'b1;
                     end
                  end
                  CMD_TICK: begin
                     if (dp_sts.armed) begin
                        if (dp_sts.rem_le1) begin
                           dp_cmd.rem_reload = 1'b1;
                           if (mode_ff == MODE_PULSING) begin
                              dp_cmd.rsp_pulse = 1'b1;
                              mode_in          = MODE_WAITING;
                           end else if (mode_ff == MODE_WAITING) begin
                              dp_cmd.rsp_missed = 1'b1;
                           end else begin
                              dp_cmd.rsp_error = 1'b1;
                           end
                        end else begin
                           dp_cmd.rem_dec = 1'b1;
                        end
                     end
                  end
                  CMD_ACK: begin
                     if (mode_ff == MODE_WAITING) begin
                        mode_in = MODE_PULSING;
                     end else if (mode_ff == MODE_PULSING) begin
                        dp_cmd.rsp_error = 1'b1;
                        mode_in          = MODE_STOPPED;
                     end else begin
                        dp_cmd.rsp_error = 1'b1;
                     end
                  end
                  default: dp_cmd.rsp_error = 1'b1;
               endcase
            end
         end
         default: req_stall = 1'b1;
      endcase
      dp_cmd.rsp_state_code = mode_in;
   end

   assign rsp_valid_in = dp_cmd.rsp_load || (rsp_valid_ff && rsp_stall);
   assign rsp_valid    = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= FSM_IDLE;
         mode_ff      <= MODE_INITIAL;
         rsp_valid_ff <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   `PPG_ASSERT_NEXT(a_accept_decodes, clock, reset, req_valid && !req_stall, fsm_ff == FSM_DECODE, "accepted beat not decoded")
   `PPG_ASSERT_NOW(a_divide_set_freq, clock, reset, fsm_ff == FSM_DIVIDE, dp_sts.cmd == CMD_SET_FREQ, "divider running for a non set-frequency command")
   `PPG_ASSERT_NOW(a_arm_pulsing, clock, reset, dp_cmd.arm_set, mode_in == MODE_PULSING, "timer armed outside pulsing")
   `PPG_ASSERT_NEXT(a_result_posted, clock, reset, dp_cmd.rsp_load, rsp_valid, "result beat not presented")

endmodule

`default_nettype wire

### rtl/periodic_pulse_generator_fsm.sv
// Periodic pulse generator with a four-state controller (initial, stopped, pulsing, waiting
// for acknowledge) and a reloading tick counter. A set-frequency command with a legal
// frequency goes through decode, the 20-step restoring divider that works out the period
// from the tick rate, and finish before its result beat; every other command, a rejected
// frequency included, goes from decode straight to finish. One item is in work at a time,
// and the next item is taken while the previous result beat still waits.
// Depends on ppg_pkg, ppg_ctrl and ppg_dpath.
`default_nettype none

module periodic_pulse_generator_fsm (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [2:0]                         req_command,
   input  logic [ppg_pkg::FREQ_WIDTH-1:0]     req_frequency,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_pulse,
   output logic                               rsp_missed,
   output logic                               rsp_error,
   output logic [1:0]                         rsp_state_code,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [ppg_pkg::CSR_ADDR_WIDTH-1:0] csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import ppg_pkg::*;

   dp_cmd_type dp_cmd;
   dp_sts_type dp_sts;

   ppg_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .dp_cmd    (dp_cmd),
      .dp_sts    (dp_sts)
   );

   ppg_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .req_command    (req_command),
      .req_frequency  (req_frequency),
      .rsp_pulse      (rsp_pulse),
      .rsp_missed     (rsp_missed),
      .rsp_error      (rsp_error),
      .rsp_state_code (rsp_state_code),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready),
      .dp_cmd         (dp_cmd),
      .dp_sts         (dp_sts)
   );

endmodule

`default_nettype wire
